[hdl/jhsp_pkg.sv]
package jhsp_pkg;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_ID    = 2'd1,
		ST_RESERVED  = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	localparam logic [3:0]  HS_PAGES_KNOWN   = 4'd13;
	localparam logic [3:0]  HS_PAGES_UNKNOWN = 4'd9;
	localparam logic [7:0]  FLAGS_RESERVED   = 8'hFC;
	localparam logic [2:0]  RTS_LONG_FORM    = 3'b111;
	localparam logic [31:0] REF_ONE_BYTE_MAX = 32'd256;
	localparam logic [31:0] REF_TWO_BYTE_MAX = 32'd65536;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] page_width;
		logic [31:0] page_height;
		logic [3:0]  hdr_len;
	} res_t;

	function automatic logic [7:0] id_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'h97;
			3'd1: v = 8'h4a;
			3'd2: v = 8'h42;
			3'd3: v = 8'h32;
			3'd4: v = 8'h0d;
			3'd5: v = 8'h0a;
			3'd6: v = 8'h1a;
			3'd7: v = 8'h0a;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

[hdl/jhsp_in_stage.sv]
module jhsp_in_stage
	import jhsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_byte
	input  logic        s_tlast,
	input  logic        step,
	output logic        valid_s1,
	output item_t       item_s1
);

	logic valid_q;

	// slot frees up whenever the held byte is consumed this cycle
	assign s_tready = !valid_q || step;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{data_byte: s_tdata, first_byte: s_tuser, last_byte: s_tlast};
		end
	end

endmodule

[hdl/jhsp_core.sv]
module jhsp_core
	import jhsp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  logic  take,
	output logic  res_valid,
	output res_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_ID, PH_FLAGS, PH_PAGES, PH_SEGNUM, PH_SEGFLG,
		PH_RTS, PH_RTSLONG, PH_SKIP, PH_WIDTH, PH_HEIGHT, PH_DONE
	} phase_t;

	phase_t      phase_q, cur_phase, nxt_phase;
	logic [2:0]  idx_q, cur_idx, nxt_idx;
	logic [31:0] shift_q, cur_shift, nxt_shift;
	logic [31:0] seg_q, cur_seg, nxt_seg;
	logic        long_q, cur_long, nxt_long;
	logic [31:0] skip_q, cur_skip, nxt_skip;
	logic [31:0] width_q, cur_width, nxt_width;
	logic        pk_q, cur_pk, nxt_pk;
	logic        res_valid_q;
	res_t        res_q;

	logic        emit;
	res_t        emit_res;
	logic [31:0] sh;
	logic [1:0]  ref_shift;
	logic [28:0] ref_cnt;
	logic [31:0] retention;
	logic [31:0] refs_len;
	logic [31:0] assoc_len;
	logic [31:0] skip_total;
	logic [31:0] skip_dec;

	always_comb begin
		if (item.first_byte) begin
			cur_phase = PH_ID;
			cur_idx   = '0;
			cur_shift = '0;
			cur_seg   = '0;
			cur_long  = 1'b0;
			cur_skip  = '0;
			cur_width = '0;
			cur_pk    = 1'b0;
		end else begin
			cur_phase = phase_q;
			cur_idx   = idx_q;
			cur_shift = shift_q;
			cur_seg   = seg_q;
			cur_long  = long_q;
			cur_skip  = skip_q;
			cur_width = width_q;
			cur_pk    = pk_q;
		end

		sh = {cur_shift[23:0], item.data_byte};

		// referred-to numbers are 1, 2 or 4 bytes wide
		if (cur_seg <= REF_ONE_BYTE_MAX) begin
			ref_shift = 2'd0;
		end else if (cur_seg <= REF_TWO_BYTE_MAX) begin
			ref_shift = 2'd1;
		end else begin
			ref_shift = 2'd2;
		end

		if (cur_phase == PH_RTSLONG) begin
			ref_cnt   = sh[28:0];
			retention = ({3'b000, sh[28:0]} + 32'd8) >> 3;
		end else begin
			ref_cnt   = {26'd0, item.data_byte[7:5]};
			retention = '0;
		end
		refs_len   = {3'b000, ref_cnt} << ref_shift;
		assoc_len  = cur_long ? 32'd4 : 32'd1;
		skip_total = retention + refs_len + assoc_len + 32'd4;
		skip_dec   = (cur_skip != '0) ? cur_skip - 32'd1 : '0;

		nxt_phase = cur_phase;
		nxt_idx   = cur_idx;
		nxt_shift = cur_shift;
		nxt_seg   = cur_seg;
		nxt_long  = cur_long;
		nxt_skip  = cur_skip;
		nxt_width = cur_width;
		nxt_pk    = cur_pk;
		emit      = 1'b0;
		emit_res  = '{status: ST_OK, page_width: '0, page_height: '0, hdr_len: '0};

		case (cur_phase)
			PH_ID: begin
				if (item.data_byte != id_byte(cur_idx)) begin
					emit            = 1'b1;
					emit_res.status = ST_BAD_ID;
				end else if (cur_idx == 3'd7) begin
					nxt_idx   = '0;
					nxt_phase = PH_FLAGS;
				end else begin
					nxt_idx = cur_idx + 3'd1;
				end
			end
			PH_FLAGS: begin
				if ((item.data_byte & FLAGS_RESERVED) != '0) begin
					emit            = 1'b1;
					emit_res.status = ST_RESERVED;
				end else begin
					nxt_pk    = !item.data_byte[1];
					nxt_idx   = '0;
					nxt_shift = '0;
					nxt_phase = item.data_byte[1] ? PH_SEGNUM : PH_PAGES;
				end
			end
			PH_PAGES: begin
				if (cur_idx >= 3'd3) begin
					nxt_idx   = '0;
					nxt_shift = '0;
					nxt_phase = PH_SEGNUM;
				end else begin
					nxt_idx = cur_idx + 3'd1;
				end
			end
			PH_SEGNUM: begin
				if (cur_idx >= 3'd3) begin
					nxt_seg   = sh;
					nxt_idx   = '0;
					nxt_shift = '0;
					nxt_phase = PH_SEGFLG;
				end else begin
					nxt_shift = sh;
					nxt_idx   = cur_idx + 3'd1;
				end
			end
			PH_SEGFLG: begin
				nxt_long  = item.data_byte[6];
				nxt_phase = PH_RTS;
			end
			PH_RTS: begin
				if (item.data_byte[7:5] == RTS_LONG_FORM) begin
					nxt_shift = {24'd0, item.data_byte};
					nxt_idx   = 3'd1;
					nxt_phase = PH_RTSLONG;
				end else begin
					nxt_skip  = skip_total;
					nxt_phase = PH_SKIP;
				end
			end
			PH_RTSLONG: begin
				if (cur_idx >= 3'd3) begin
					nxt_idx   = '0;
					nxt_shift = '0;
					nxt_skip  = skip_total;
					nxt_phase = PH_SKIP;
				end else begin
					nxt_shift = sh;
					nxt_idx   = cur_idx + 3'd1;
				end
			end
			PH_SKIP: begin
				nxt_skip = skip_dec;
				if (skip_dec == '0) begin
					nxt_idx   = '0;
					nxt_shift = '0;
					nxt_phase = PH_WIDTH;
				end
			end
			PH_WIDTH: begin
				if (cur_idx >= 3'd3) begin
					nxt_width = sh;
					nxt_idx   = '0;
					nxt_shift = '0;
					nxt_phase = PH_HEIGHT;
				end else begin
					nxt_shift = sh;
					nxt_idx   = cur_idx + 3'd1;
				end
			end
			PH_HEIGHT: begin
				nxt_shift = sh;
				if (cur_idx >= 3'd3) begin
					emit                 = 1'b1;
					emit_res.page_width  = cur_width;
					emit_res.page_height = sh;
					emit_res.hdr_len     = cur_pk ? HS_PAGES_KNOWN : HS_PAGES_UNKNOWN;
				end else begin
					nxt_idx = cur_idx + 3'd1;
				end
			end
			default: begin
			end
		endcase

		// stream ran out mid-header; an error on the same byte wins
		if (!emit && item.last_byte && cur_phase != PH_IDLE && cur_phase != PH_DONE) begin
			emit            = 1'b1;
			emit_res.status = ST_TRUNCATED;
		end
		if (emit) begin
			nxt_phase = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			idx_q       <= '0;
			shift_q     <= '0;
			seg_q       <= '0;
			long_q      <= 1'b0;
			skip_q      <= '0;
			width_q     <= '0;
			pk_q        <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (step) begin
				phase_q <= nxt_phase;
				idx_q   <= nxt_idx;
				shift_q <= nxt_shift;
				seg_q   <= nxt_seg;
				long_q  <= nxt_long;
				skip_q  <= nxt_skip;
				width_q <= nxt_width;
				pk_q    <= nxt_pk;
			end
			if (step && emit) begin
				res_valid_q <= 1'b1;
				res_q       <= emit_res;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_OK |->
			(res_q.hdr_len == HS_PAGES_KNOWN || res_q.hdr_len == HS_PAGES_UNKNOWN))
		else $error("ok result with bad header size");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status != ST_OK |->
			(res_q.page_width == '0 && res_q.page_height == '0 && res_q.hdr_len == '0))
		else $error("error result with nonzero fields");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.first_byte && phase_q == PH_IDLE |=> phase_q == PH_IDLE)
		else $error("parser left idle without a first byte");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> phase_q == PH_DONE && res_valid_q)
		else $error("result issued but parser not done");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.first_byte && (phase_q == PH_IDLE || phase_q == PH_DONE) |-> !emit)
		else $error("result from an idle parser");

endmodule

[hdl/jbig2_header_size_parser.sv]
// Byte-stream parser for the JBIG2 file header and first segment header. One byte is
// taken per clock unless stalled: each byte sits in an input register until a short
// step of the header state machine consumes it, and the single result per file (status,
// page width, page height, header size) lands in an output register. A result that is
// not taken holds that register; the parser then stops after the one byte already in
// the input register, so sustained rate is one byte per cycle with m_tready high, and
// the result is registered as its final byte is consumed. s_tuser restarts the parser;
// bytes before a restart or after a result are dropped without output.
module jbig2_header_size_parser
	import jhsp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [31:0] page_width, [63:32] page_height,
	                               // [67:64] hdr_len, [71:68] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic  valid_s1;
	item_t item_s1;
	logic  step;
	logic  res_valid;
	res_t  res;

	// consume the held byte only when the result slot is free or draining
	assign step = valid_s1 && (!res_valid || m_tready);

	jhsp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.step     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	jhsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.take      (m_tready),
		.res_valid (res_valid),
		.res       (res)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {4'd0, res.hdr_len, res.page_height, res.page_width};
	assign m_tuser  = res.status;

endmodule
